// ----- rtl/core/cordic_cartesian_to_polar_core_assert.svh -----
// assertion macros for the cartesian to polar core
`ifndef CORDIC_CARTESIAN_TO_POLAR_CORE_ASSERT_SVH
`define CORDIC_CARTESIAN_TO_POLAR_CORE_ASSERT_SVH

// same-cycle implication
`define CCP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/ccp_pkg.sv -----
`timescale 1ns / 1ps

package ccp_pkg;

   localparam int ITERATIONS_DEFAULT = 16;
   localparam int ROM_SIZE           = 20;
   localparam int XY_W               = 18;
   localparam int ANG_W              = 16;
   localparam int IN_W               = 16;
   localparam int MAG_W              = 15;

   localparam logic signed [ANG_W-1:0] ANGLE_PI = 16'sd25736;

   // magnitude = floor((x * 60725 + 50000) / 100000), done as >> 5 then / 3125
   localparam logic [15:0] GAIN_NUM  = 16'd60725;
   localparam logic [15:0] ROUND_OFS = 16'd50000;
   localparam int          NUM_W     = 33;
   localparam int          PRE_SHIFT = 5;
   localparam int          DIV_IN_W  = NUM_W - PRE_SHIFT;
   localparam int          RECIP_W   = 29;
   // ceil(2^40 / 3125), exact for every value below 2^40 / 3125
   localparam logic [RECIP_W-1:0] RECIP = 29'd351843721;
   localparam int          RECIP_SH  = 40;
   localparam int          PROD_W    = DIV_IN_W + RECIP_W;
   localparam int          QUO_W     = PROD_W - RECIP_SH;
   localparam logic [QUO_W-1:0] MAG_MAX = 17'd32767;

   // atan(2^-j) * 8192, rounded
   function automatic logic [12:0] atan_rom(input int j);
      logic [12:0] v;
      unique case (j)
         0:       v = 13'd6434;
         1:       v = 13'd3798;
         2:       v = 13'd2007;
         3:       v = 13'd1019;
         4:       v = 13'd511;
         5:       v = 13'd256;
         6:       v = 13'd128;
         7:       v = 13'd64;
         8:       v = 13'd32;
         9:       v = 13'd16;
         10:      v = 13'd8;
         11:      v = 13'd4;
         12:      v = 13'd2;
         13:      v = 13'd1;
         default: v = 13'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/core/cordic_cartesian_to_polar_core.sv -----
// pipeline: the input stage loads at the transfer edge, then come the cordic
// micro-rotation stages, the gain multiply, reciprocal multiply and output register
// stages; all of them hold while rsp_tvalid is high and rsp_tready is low
// throughput: one point per cycle while the output is not stalled; after a stall a
// point held in the input skid register drains into the first stage while req_tready is low
// reset: synchronous, clears all valid bits and the skid full flag
`timescale 1ns / 1ps

`include "cordic_cartesian_to_polar_core_assert.svh"

module cordic_cartesian_to_polar_core #(
   parameter int ITERATIONS = ccp_pkg::ITERATIONS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // point_x [15:0], point_y [31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // magnitude [14:0], angle [30:15], zero [31]
);

   import ccp_pkg::*;

   logic enable;
   logic accept;

   // input skid register
   logic                 skid_full_ff, skid_full_in;
   logic [IN_W-1:0]      skid_x_ff, skid_y_ff;

   logic signed [IN_W-1:0] src_x, src_y;

   // cordic stages, index 0 is the input stage
   logic                    vld_ff [0:ITERATIONS];
   logic signed [XY_W-1:0]  x_ff   [0:ITERATIONS];
   logic signed [XY_W-1:0]  y_ff   [0:ITERATIONS];
   logic signed [ANG_W-1:0] th_ff  [0:ITERATIONS];
   logic                    mir_ff [0:ITERATIONS];
   logic                    pos_ff [0:ITERATIONS];

   logic signed [XY_W-1:0]  x0_in;

   // gain multiply stage
   logic                    a_vld_ff;
   logic                    a_zero_ff, a_zero_in;
   logic signed [ANG_W-1:0] a_ang_ff, a_ang_in;
   logic [NUM_W-1:0]        a_num_ff, a_num_in;

   // reciprocal multiply stage
   logic                    b_vld_ff;
   logic                    b_zero_ff;
   logic signed [ANG_W-1:0] b_ang_ff;
   logic [PROD_W-1:0]       b_prod_ff, b_prod_in;

   // output register
   logic                    rsp_vld_ff;
   logic [MAG_W-1:0]        rsp_mag_ff, rsp_mag_in;
   logic signed [ANG_W-1:0] rsp_ang_ff;
   logic [QUO_W-1:0]        quo;

   assign enable     = !rsp_vld_ff || rsp_tready;
   assign req_tready = !skid_full_ff;
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {1'b0, rsp_ang_ff, rsp_mag_ff};

   // skid register
   always_comb begin
      skid_full_in = skid_full_ff;
      if (enable) begin
         skid_full_in = 1'b0;
      end else if (accept) begin
         skid_full_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
      end else begin
         skid_full_ff <= skid_full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!enable && accept) begin
         skid_x_ff <= req_tdata[15:0];
         skid_y_ff <= req_tdata[31:16];
      end
   end

   // input stage, mirror negative x
   always_comb begin
      src_x = skid_full_ff ? skid_x_ff : req_tdata[15:0];
      src_y = skid_full_ff ? skid_y_ff : req_tdata[31:16];
      x0_in = src_x[IN_W-1] ? -XY_W'(src_x) : XY_W'(src_x);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (enable) begin
         vld_ff[0] <= skid_full_ff || accept;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]   <= x0_in;
         y_ff[0]   <= XY_W'(src_y);
         th_ff[0]  <= '0;
         mir_ff[0] <= src_x[IN_W-1];
         pos_ff[0] <= !src_y[IN_W-1] && (src_y != '0);
      end
   end

   // micro-rotation stages
   for (genvar k = 1; k <= ITERATIONS; k++) begin : g_stage
      localparam int J = k - 1;
      localparam logic signed [ANG_W-1:0] ROM_J = ANG_W'(atan_rom(J));

      logic signed [XY_W-1:0]  neg_x, neg_y, dx, dy;
      logic signed [XY_W-1:0]  x_in, y_in;
      logic signed [ANG_W-1:0] th_in;

      always_comb begin
         neg_x = -x_ff[k-1];
         neg_y = -y_ff[k-1];
         if (y_ff[k-1][XY_W-1]) begin
            dx    = x_ff[k-1] >>> J;
            dy    = y_ff[k-1] >>> J;
            th_in = th_ff[k-1] - ROM_J;
         end else begin
            dx    = neg_x >>> J;
            dy    = neg_y >>> J;
            th_in = th_ff[k-1] + ROM_J;
         end
         x_in = x_ff[k-1] - dy;
         y_in = y_ff[k-1] + dx;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (enable) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            x_ff[k]   <= x_in;
            y_ff[k]   <= y_in;
            th_ff[k]  <= th_in;
            mir_ff[k] <= mir_ff[k-1];
            pos_ff[k] <= pos_ff[k-1];
         end
      end
   end

   // angle correction and gain multiply
   always_comb begin
      a_zero_in = x_ff[ITERATIONS][XY_W-1] || (x_ff[ITERATIONS] == '0);
      a_num_in  = NUM_W'(x_ff[ITERATIONS][XY_W-2:0]) * NUM_W'(GAIN_NUM)
                  + NUM_W'(ROUND_OFS);
      if (!mir_ff[ITERATIONS]) begin
         a_ang_in = th_ff[ITERATIONS];
      end else if (pos_ff[ITERATIONS]) begin
         a_ang_in = ANGLE_PI - th_ff[ITERATIONS];
      end else begin
         a_ang_in = -ANGLE_PI - th_ff[ITERATIONS];
      end
   end

   // divide by 3125 through the reciprocal
   assign b_prod_in = PROD_W'(a_num_ff[NUM_W-1:PRE_SHIFT]) * PROD_W'(RECIP);

   always_comb begin
      quo = b_prod_ff[PROD_W-1:RECIP_SH];
      if (b_zero_ff) begin
         rsp_mag_in = '0;
      end else if (quo > MAG_MAX) begin
         rsp_mag_in = MAG_MAX[MAG_W-1:0];
      end else begin
         rsp_mag_in = quo[MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (enable) begin
         a_vld_ff   <= vld_ff[ITERATIONS];
         b_vld_ff   <= a_vld_ff;
         rsp_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_zero_ff  <= a_zero_in;
         a_ang_ff   <= a_ang_in;
         a_num_ff   <= a_num_in;
         b_zero_ff  <= a_zero_ff;
         b_ang_ff   <= a_ang_ff;
         b_prod_ff  <= b_prod_in;
         rsp_mag_ff <= rsp_mag_in;
         rsp_ang_ff <= b_ang_ff;
      end
   end

   `CCP_ASSERT_NEXT(a_skid_holds, clock, reset, skid_full_ff && !enable, skid_full_ff, "skid lost a transfer")
   `CCP_ASSERT_NEXT(a_skid_fill, clock, reset, accept && !enable, skid_full_ff, "stalled transfer not stored")
   `CCP_ASSERT_IMP(a_mirror_pos, clock, reset, vld_ff[0], !x_ff[0][XY_W-1], "mirrored x is negative")
   `CCP_ASSERT_NEXT(a_tail_moves, clock, reset, b_vld_ff && enable, rsp_vld_ff, "result dropped at output")

endmodule

// ----- test/cordic_polar_checker.sv -----
`timescale 1ns / 1ps

module cordic_polar_checker #(
   parameter int ITERATIONS = ccp_pkg::ITERATIONS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // point_x [15:0], point_y [31:16]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // magnitude [14:0], angle [30:15], zero [31]
   output int          outstanding,
   output int          failures
);

   typedef struct packed {
      logic signed [15:0] angle;
      logic [14:0]        magnitude;
   } polar_type;

   localparam int  LUT_DEPTH   = 20;
   localparam int  GAIN_SCALED = 60725;
   localparam int  GAIN_ROUND  = 50000;
   localparam int  GAIN_DIV    = 100000;
   localparam int  MAG_CEILING = 32767;

   // arctangent of 2^-j in radians times 8192
   int atan_lut [0:LUT_DEPTH-1] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16,
                                    8, 4, 2, 1, 0, 0, 0, 0, 0, 0};

   polar_type polar_q[$];
   polar_type seen;
   polar_type want;
   int        fail_total = 0;

   function automatic polar_type to_polar(logic signed [15:0] px, logic signed [15:0] py);
      int        x;
      int        y;
      int        theta;
      int        dx;
      int        dy;
      int        steps;
      longint    scaled;
      polar_type r;
      steps = (ITERATIONS > LUT_DEPTH) ? LUT_DEPTH : ITERATIONS;
      x = (px < 0) ? -int'(px) : int'(px);
      y = int'(py);
      theta = 0;
      for (int j = 0; j < steps; j++) begin
         if (y < 0) begin
            dx = x >>> j;
            dy = y >>> j;
            theta = theta - atan_lut[j];
         end else begin
            dx = (-x) >>> j;
            dy = (-y) >>> j;
            theta = theta + atan_lut[j];
         end
         x = x - dy;
         y = y + dx;
      end
      // left half plane: fold the angle back across the y axis
      if (px < 0) begin
         if (py > 0) theta = int'(ccp_pkg::ANGLE_PI) - theta;
         else theta = -int'(ccp_pkg::ANGLE_PI) - theta;
      end
      if (x <= 0) begin
         scaled = 0;
      end else begin
         scaled = (longint'(x) * GAIN_SCALED + GAIN_ROUND) / GAIN_DIV;
         if (scaled > MAG_CEILING) scaled = MAG_CEILING;
      end
      r.magnitude = scaled[14:0];
      r.angle     = theta[15:0];
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            polar_q.push_back(to_polar(req_tdata[15:0], req_tdata[31:16]));
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[30:0];
            if (rsp_tdata[31] !== 1'b0) begin
               $error("zero mismatch: expected 0, got %b", rsp_tdata[31]);
               fail_total++;
            end
            if (polar_q.size() == 0) begin
               $error("result transfer with no point pending: magnitude %0d angle %0d",
                      seen.magnitude, seen.angle);
               fail_total++;
            end else begin
               want = polar_q.pop_front();
               if (seen.magnitude !== want.magnitude) begin
                  $error("magnitude mismatch: expected %0d, got %0d",
                         want.magnitude, seen.magnitude);
                  fail_total++;
               end
               if (seen.angle !== want.angle) begin
                  $error("angle mismatch: expected %0d, got %0d", want.angle, seen.angle);
                  fail_total++;
               end
            end
         end
      end
      outstanding <= polar_q.size();
      failures    <= fail_total;
   end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   localparam int ITER         = ccp_pkg::ITERATIONS_DEFAULT;
   localparam int RANDOM_ITEMS = 450;
   localparam int HOLD_CYCLES  = 150;
   localparam int HOLD_AFTER   = 60;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   int          outstanding;
   int          failures;
   int          points_sent = 0;
   bit          calm = 0;
   bit          held = 0;

   cordic_cartesian_to_polar_core #(
      .ITERATIONS (ITER)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   cordic_polar_checker #(
      .ITERATIONS (ITER)
   ) i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .outstanding (outstanding),
      .failures    (failures)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("Test completed with failures");
      $finish;
   end

   task automatic send_point(input logic signed [15:0] px, input logic signed [15:0] py);
      if (!calm && $urandom_range(99) < 11) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {py, px};
      do @(posedge clock); while (!req_tready);
      points_sent++;
   endtask

   function automatic logic signed [15:0] pick_coord();
      int sel;
      sel = $urandom_range(99);
      if (sel < 10) return 16'($urandom);
      if (sel < 20) return 16'($urandom_range(20) - 10);
      return 16'($urandom_range(40000) - 20000);
   endfunction

   // result side: random backpressure plus one long hold-off
   initial begin
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (!held && points_sent >= HOLD_AFTER) begin
            held = 1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 11);
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // origin, axes, corners, left half plane on the negative axis, full-scale codes
      send_point(16'sd0, 16'sd0);
      send_point(16'sd20000, 16'sd0);
      send_point(-16'sd20000, 16'sd0);
      send_point(16'sd0, 16'sd20000);
      send_point(16'sd0, -16'sd20000);
      send_point(16'sd20000, 16'sd20000);
      send_point(-16'sd20000, 16'sd20000);
      send_point(-16'sd20000, -16'sd20000);
      send_point(16'sd20000, -16'sd20000);
      send_point(-16'sd1, 16'sd0);
      send_point(-16'sd1, 16'sd1);
      send_point(-16'sd1, -16'sd1);
      send_point(16'sd1, 16'sd0);
      send_point(16'sd1, 16'sd1);
      send_point(-16'sd20000, 16'sd1);
      send_point(16'sd10000, -16'sd1);
      send_point(-16'sd5, 16'sd0);
      send_point(16'sd32767, 16'sd32767);
      send_point(-16'sd32768, -16'sd32768);
      send_point(-16'sd32768, 16'sd32767);
      send_point(16'sd32767, -16'sd32768);
      send_point(-16'sd32768, 16'sd0);
      send_point(16'sd0, -16'sd32768);

      req_tvalid <= 1'b0;
      wait (outstanding == 0);
      @(posedge clock);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         calm = (i >= 150 && i < 250);
         if (i == 320) begin
            req_tvalid <= 1'b0;
            wait (outstanding == 0);
            @(posedge clock);
         end
         send_point(pick_coord(), pick_coord());
      end
      calm = 0;
      req_tvalid <= 1'b0;

      wait (outstanding == 0);
      repeat (ITER + 10) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
